/* sv/upd_pkg.sv */
package upd_pkg;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  localparam int MAX_CAND = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       truncated;
  } out_item_t;

  // One parsed item: up to three candidate bytes, in order, ahead of the capacity check
  typedef struct packed {
    logic [MAX_CAND-1:0][7:0] cand;
    logic [1:0]               n_cand;
    logic                     last;
  } cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

/* sv/upd_front.sv */
module upd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_ready,
  input  upd_pkg::in_item_t src_item,
  input  logic             q_ready,
  output logic             push,
  output upd_pkg::cmd_t    cmd
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_HEX  = 2'd2;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] held;
  logic [7:0] held_next;

  assign src_ready = q_ready;
  assign push      = src_valid && q_ready;

  always_comb begin
    logic [7:0] b;
    logic       last;
    logic [1:0] n;
    logic       reparse;
    b          = src_item.in_byte;
    last       = src_item.in_last;
    n          = 2'd0;
    reparse    = 1'b0;
    cmd        = '0;
    phase_next = PH_IDLE;
    held_next  = held;
    case (phase)
      PH_PCT: begin
        if (upd_pkg::is_hex(b) && !last) begin
          held_next  = b;
          phase_next = PH_HEX;
        end else begin
          cmd.cand[0] = upd_pkg::CHAR_PERCENT;
          n           = 2'd1;
          reparse     = 1'b1;
        end
      end
      PH_HEX: begin
        if (upd_pkg::is_hex(held) && upd_pkg::is_hex(b)) begin
          cmd.cand[0] = {upd_pkg::hex_nibble(held), upd_pkg::hex_nibble(b)};
          n           = 2'd1;
        end else begin
          // bad escape: pass '%' and the held digit through, then reparse
          cmd.cand[0] = upd_pkg::CHAR_PERCENT;
          cmd.cand[1] = held;
          n           = 2'd2;
          reparse     = 1'b1;
        end
      end
      default: begin
        reparse = 1'b1;
      end
    endcase
    if (reparse) begin
      if (b == upd_pkg::CHAR_PLUS) begin
        cmd.cand[n] = upd_pkg::CHAR_SPACE;
        n           = n + 2'd1;
      end else if (b == upd_pkg::CHAR_PERCENT && !last) begin
        phase_next = PH_PCT;
      end else begin
        cmd.cand[n] = b;
        n           = n + 2'd1;
      end
    end
    if (last) begin
      phase_next = PH_IDLE;
      held_next  = '0;
    end
    cmd.n_cand = n;
    cmd.last   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= '0;
    end else if (push) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

endmodule

/* sv/upd_queue.sv */
module upd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  upd_pkg::cmd_t push_cmd,
  output logic          ready,
  input  logic          pop,
  output logic          head_valid,
  output upd_pkg::cmd_t head_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  upd_pkg::cmd_t   slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;

  assign ready      = (fill != CW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

/* sv/upd_back.sv */
module upd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       max_bytes,
  input  logic              cmd_valid,
  input  upd_pkg::cmd_t     cmd,
  output logic              pop,
  output logic              dst_valid,
  input  logic              dst_ready,
  output upd_pkg::out_item_t dst_item
);

  logic [1:0]  idx;
  logic [1:0]  idx_next;
  logic [15:0] count;
  logic [15:0] count_next;
  logic        dropped;
  logic        dropped_next;
  logic        adv;
  logic        step;
  logic        emit;
  logic        done;
  upd_pkg::out_item_t res;

  assign adv  = !dst_valid || dst_ready;
  assign step = cmd_valid && adv;
  assign pop  = step && done;

  // One candidate byte per cycle against the capacity, while the output can advance
  always_comb begin
    logic fits;
    logic cap_hit;
    logic at_end;
    logic step_end;
    fits         = (count < max_bytes);
    cap_hit      = (({1'b0, count} + 17'd1) == {1'b0, max_bytes});
    at_end       = (idx == (cmd.n_cand - 2'd1));
    step_end     = at_end || cap_hit;
    emit         = 1'b0;
    done         = 1'b0;
    res          = '0;
    idx_next     = idx;
    count_next   = count;
    dropped_next = dropped;
    if (cmd.n_cand == 2'd0) begin
      done              = 1'b1;
      emit              = cmd.last;
      res.end_of_string = 1'b1;
      res.truncated     = dropped;
    end else if (fits) begin
      emit              = 1'b1;
      res.out_byte      = cmd.cand[idx];
      res.byte_valid    = 1'b1;
      res.end_of_string = cmd.last && step_end;
      res.truncated     = dropped || (cmd.last && step_end && !at_end);
      count_next        = count + 16'd1;
      if (step_end) begin
        done = 1'b1;
        if (!at_end) begin
          dropped_next = 1'b1;
        end
      end else begin
        idx_next = idx + 2'd1;
      end
    end else begin
      // capacity already full: drop the rest, blank end mark on a last item if nothing went out
      dropped_next      = 1'b1;
      done              = 1'b1;
      emit              = cmd.last && (idx == 2'd0);
      res.end_of_string = 1'b1;
      res.truncated     = 1'b1;
    end
    if (done) begin
      idx_next = 2'd0;
      if (cmd.last) begin
        count_next   = '0;
        dropped_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      count     <= '0;
      dropped   <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      if (step) begin
        idx     <= idx_next;
        count   <= count_next;
        dropped <= dropped_next;
      end
      if (adv) begin
        dst_valid <= step && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dst_item <= res;
    end
  end

endmodule

/* sv/url_percent_decoder_top.sv */
// Channel   Direction  Handshake              Payload
// src       input      src_valid / src_ready  src_item (in_byte, in_last)
// dst       output     dst_valid / dst_ready  dst_item (out_byte, byte_valid,
//                                             end_of_string, truncated)
// cfg       input      cfg_wr_en              cfg_wr_data (max_output_bytes)
//
// The front end parses one byte per cycle while the queue has room; the back end
// handles candidate bytes singly, so items yielding at most one byte sustain
// one per cycle while dst_ready holds; broken escapes yield more and are
// absorbed by the QUEUE_DEPTH command queue. Synchronous reset clears escape
// state, counters, queue and output valid, and sets max_output_bytes to 65535.
// src_ready drops only when the queue is full.
module url_percent_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               src_valid,
  output logic               src_ready,
  input  upd_pkg::in_item_t  src_item,
  output logic               dst_valid,
  input  logic               dst_ready,
  output upd_pkg::out_item_t dst_item
);

  logic [15:0]   max_output_bytes;
  logic          push;
  logic          q_ready;
  logic          pop;
  logic          head_valid;
  upd_pkg::cmd_t push_cmd;
  upd_pkg::cmd_t head_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output_bytes <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      max_output_bytes <= cfg_wr_data;
    end
  end

  upd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .q_ready   (q_ready),
    .push      (push),
    .cmd       (push_cmd)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .max_bytes (max_output_bytes),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .pop       (pop),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_item  (dst_item)
  );

endmodule
